/* design/cke_pkg.sv */
// Shared types and constants for the canonical k-mer extractor.
// Used by cke_cell, canonical_kmer_extractor and tb; depends on nothing else.
`default_nettype none
package cke_pkg;

  // two-bit base code, A=0 C=1 G=2 T=3
  typedef logic [1:0] base_t;

  localparam base_t BASE_A = 2'd0;
  localparam base_t BASE_C = 2'd1;
  localparam base_t BASE_G = 2'd2;
  localparam base_t BASE_T = 2'd3;

  // ASCII upper-case letters and the case-fold mask
  localparam logic [7:0] FOLD_MASK = 8'hDF;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_T    = 8'h54;

  // width of the k-mer length register
  localparam int unsigned KLEN_W = 6;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 6'd31;

  // width of the packed k-mer words
  localparam int unsigned KMER_W  = 64;
  localparam int unsigned START_W = 16;

  // per-cycle control fanned out to every window cell
  typedef struct packed {
    logic shift;  // a valid base was accepted: move the window by one base
    logic clear;  // end of read: empty the window after this request
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/cke_cell.sv */
// One base slot of the rolling window: holds a base, passes it to the older
// neighbor and produces its forward and reverse-complement groups. Uses cke_pkg.
`default_nettype none
module cke_cell #(
  parameter int unsigned POS = 0
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire cke_pkg::cell_ctrl_t        ctrl,
  input  wire cke_pkg::base_t             base_in,
  input  wire [cke_pkg::KLEN_W-1:0]       k,
  output cke_pkg::base_t                  base,
  output cke_pkg::base_t                  fwd_group,
  output cke_pkg::base_t                  rc_group
);

  localparam logic [cke_pkg::KLEN_W-1:0] POS_V = cke_pkg::KLEN_W'(POS);

  cke_pkg::base_t base_shift;
  logic           active;

  // take the younger neighbor's base on a shift, else hold
  assign base_shift = ctrl.shift ? base_in : base;

  // this slot lies inside the current k-mer
  assign active = (POS_V < k);

  // contribute to the k-mer words from the post-shift value
  assign fwd_group = active ? base_shift : cke_pkg::BASE_A;
  assign rc_group  = active ? ~base_shift : cke_pkg::BASE_A;

  // hold the base, empty on end of read
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= cke_pkg::BASE_A;
    end else if (ctrl.clear) begin
      base <= cke_pkg::BASE_A;
    end else begin
      base <= base_shift;
    end
  end

endmodule
`default_nettype wire

/* design/canonical_kmer_extractor.sv */
// Top level of the canonical k-mer extractor: decode, window cell row,
// run and position counters, canonical select and output register. Uses cke_pkg, cke_cell.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: base_char; tuser: end_of_read
//   m_*      out  m_tvalid/m_tready  tdata: kmer_start, forward, canonical;
//                                    tuser: took_reverse
//   cfg_*    in   cfg_we             cfg_wdata: kmer_length
//
// One request per cycle, sustained while the output is not stalled; a result appears in the
// cycle after its request is accepted, from the single output register behind the window row.
// Reset is synchronous; it empties the window and counters, k returns to 31.
// s_tready is low only while a result waits in the output register and
// m_tready is low; an invalid character or a short run yields no result.
`default_nettype none
module canonical_kmer_extractor #(
  parameter int unsigned MAX_BASES  = 32,
  parameter int unsigned INDEX_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,    // [7:0] base_char
  input  wire  [0:0]   s_tuser,    // [0] end_of_read
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [143:0] m_tdata,    // [15:0] kmer_start, [79:16] forward_kmer,
                                   // [143:80] canonical_kmer
  output logic [0:0]   m_tuser,    // [0] took_reverse
  input  wire          cfg_we,
  input  wire  [cke_pkg::KLEN_W-1:0] cfg_wdata
);

  localparam int unsigned KW    = cke_pkg::KLEN_W;
  localparam int unsigned RUN_W = $clog2(MAX_BASES + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_BASES);
  localparam logic [KW-1:0]    K_MAX   = KW'(MAX_BASES);

  logic [KW-1:0]         kmer_length;
  logic [KW-1:0]         k_eff;
  logic [RUN_W-1:0]      run;
  logic [RUN_W-1:0]      run_inc;
  logic [INDEX_BITS-1:0] char_index;
  logic [INDEX_BITS-1:0] idx_start;

  logic [7:0]          folded;
  cke_pkg::base_t      code;
  logic                code_ok;
  logic                in_fire;
  logic                eor;
  logic                emit;
  cke_pkg::cell_ctrl_t ctrl;

  cke_pkg::base_t cell_base [MAX_BASES];
  cke_pkg::base_t fwd_grp   [MAX_BASES];
  cke_pkg::base_t rc_grp    [MAX_BASES];

  logic [cke_pkg::KMER_W-1:0] win_word;
  logic [cke_pkg::KMER_W-1:0] fwd_word;
  logic [cke_pkg::KMER_W-1:0] rc_word;
  logic [6:0]                 shamt;
  logic                       rev;

  // hold the k-mer length register
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= cke_pkg::KLEN_RESET;
    end else if (cfg_we) begin
      kmer_length <= cfg_wdata;
    end
  end

  // clamp k into 1..MAX_BASES
  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KW'(1);
    end else if (kmer_length > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = kmer_length;
    end
  end

  // fold case and decode the character
  assign folded = s_tdata[7:0] & cke_pkg::FOLD_MASK;
  always_comb begin
    code_ok = 1'b1;
    unique case (folded)
      cke_pkg::CHAR_A: code = cke_pkg::BASE_A;
      cke_pkg::CHAR_C: code = cke_pkg::BASE_C;
      cke_pkg::CHAR_G: code = cke_pkg::BASE_G;
      cke_pkg::CHAR_T: code = cke_pkg::BASE_T;
      default: begin
        code    = cke_pkg::BASE_A;
        code_ok = 1'b0;
      end
    endcase
  end

  assign s_tready   = !m_tvalid || m_tready;
  assign in_fire    = s_tvalid && s_tready;
  assign eor        = s_tuser[0];
  assign ctrl.shift = in_fire && code_ok;
  assign ctrl.clear = in_fire && eor;

  // saturating run of valid bases
  assign run_inc = (run == RUN_MAX) ? run : run + RUN_W'(1);
  assign emit    = ctrl.shift && (KW'(run_inc) >= k_eff);

  // advance run and position, restart the run on an invalid character, drop both at end of read
  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= '0;
      char_index <= '0;
    end else if (in_fire) begin
      if (eor) begin
        run        <= '0;
        char_index <= '0;
      end else begin
        run        <= code_ok ? run_inc : '0;
        char_index <= char_index + INDEX_BITS'(1);
      end
    end
  end

  // row of window cells, newest base in cell 0
  for (genvar j = 0; j < MAX_BASES; j++) begin : g_cell
    cke_pkg::base_t nb_in;
    if (j == 0) begin : g_head
      assign nb_in = code;
    end else begin : g_tail
      assign nb_in = cell_base[j-1];
    end
    cke_cell #(.POS(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .base_in   (nb_in),
      .k         (k_eff),
      .base      (cell_base[j]),
      .fwd_group (fwd_grp[j]),
      .rc_group  (rc_grp[j])
    );
  end

  // gather cell groups: window right-aligned, reverse complement left-aligned
  always_comb begin
    win_word = '0;
    rc_word  = '0;
    for (int j = 0; j < MAX_BASES; j++) begin
      win_word[2*j +: 2]      = fwd_grp[j];
      rc_word[2*(31-j) +: 2] = rc_grp[j];
    end
  end

  // left-align the forward k-mer and pick the smaller word
  assign shamt    = 7'd64 - {k_eff, 1'b0};
  assign fwd_word = win_word << shamt;
  assign rev      = rc_word < fwd_word;
  assign idx_start = char_index - INDEX_BITS'(k_eff - KW'(1));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata[15:0]   <= cke_pkg::START_W'(idx_start);
      m_tdata[79:16]  <= fwd_word;
      m_tdata[143:80] <= rev ? rc_word : fwd_word;
      m_tuser[0]      <= rev;
    end
  end

  // canonical word never exceeds the forward word
  a_canon_le: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[143:80] <= m_tdata[79:16]))
    else $error("canonical k-mer above forward k-mer");

  // reverse flag only when the words differ
  a_rev_differs: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[143:80] != m_tdata[79:16]))
    else $error("reverse flag set on equal words");

  // end of read empties run and position
  a_eor_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && eor) |=> (run == '0 && char_index == '0))
    else $error("end of read did not clear counters");

  // run counter never exceeds the window depth
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run <= RUN_MAX)
    else $error("valid run beyond window depth");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for canonical_kmer_extractor: directed and random reads streamed in,
// k-mers predicted in step and compared at the output. Depends on cke_pkg and the design.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MAX_BASES     = 32;
  localparam int          WATCHDOG_MAX  = 2000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          PHASE_CHARS   = 125;
  localparam int          NUM_PHASES    = 10;

  // one read character request
  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
  } read_char_t;

  // one emitted k-mer
  typedef struct packed {
    logic [cke_pkg::START_W-1:0] start;
    logic [cke_pkg::KMER_W-1:0]  fwd;
    logic [cke_pkg::KMER_W-1:0]  canon;
    logic                        rev;
  } kmer_hit_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       s_tvalid  = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata   = '0;  // [7:0] base_char
  logic [0:0]                 s_tuser   = '0;  // [0] end_of_read
  logic                       m_tvalid;
  logic                       m_tready  = 1'b0;
  logic [143:0]               m_tdata;  // [15:0] start, [79:16] forward, [143:80] canonical
  logic [0:0]                 m_tuser;  // [0] took_reverse
  logic                       cfg_we    = 1'b0;
  logic [cke_pkg::KLEN_W-1:0] cfg_wdata = '0;

  read_char_t read_chars[$];
  kmer_hit_t  due_kmers[$];
  int         pushed_chars = 0;
  int         err_count    = 0;
  int         idle_cycles  = 0;
  int         send_idle    = 0;
  int         recv_stall   = 0;

  // shadow of the extractor state
  logic [cke_pkg::KLEN_W-1:0]  mdl_klen;
  logic [cke_pkg::KMER_W-1:0]  mdl_window;
  int unsigned                 mdl_run;
  logic [cke_pkg::START_W-1:0] mdl_index;

  canonical_kmer_extractor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // reverse the order of the 32 two-bit groups
  function automatic logic [cke_pkg::KMER_W-1:0] swap_pair_order(
    input logic [cke_pkg::KMER_W-1:0] v);
    logic [cke_pkg::KMER_W-1:0] r;
    for (int i = 0; i < 32; i++) r[2*i +: 2] = v[62-2*i +: 2];
    return r;
  endfunction

  // advance the shadow state by one character and queue the k-mer it yields
  function automatic void extract_kmer(input logic [7:0] ch, input logic eor);
    logic [7:0]                 folded;
    cke_pkg::base_t             code;
    logic                       is_base;
    int unsigned                k;
    int unsigned                sh;
    logic [cke_pkg::KMER_W-1:0] fwd;
    logic [cke_pkg::KMER_W-1:0] rc;
    kmer_hit_t                  hit;
    folded  = ch & cke_pkg::FOLD_MASK;
    is_base = 1'b1;
    code    = cke_pkg::BASE_A;
    case (folded)
      cke_pkg::CHAR_A: code = cke_pkg::BASE_A;
      cke_pkg::CHAR_C: code = cke_pkg::BASE_C;
      cke_pkg::CHAR_G: code = cke_pkg::BASE_G;
      cke_pkg::CHAR_T: code = cke_pkg::BASE_T;
      default: is_base = 1'b0;
    endcase
    // zero length acts as one, anything past the window acts as the window
    k = 32'(mdl_klen);
    if (k == 0) k = 1;
    if (k > MAX_BASES) k = MAX_BASES;
    if (is_base) begin
      mdl_window = {mdl_window[cke_pkg::KMER_W-3:0], code};
      if (mdl_run < MAX_BASES) mdl_run++;
      if (mdl_run >= k) begin
        sh        = cke_pkg::KMER_W - 2 * k;
        fwd       = mdl_window << sh;
        rc        = swap_pair_order(~fwd) << sh;
        hit.start = mdl_index - cke_pkg::START_W'(k - 1);
        hit.fwd   = fwd;
        hit.rev   = (rc < fwd);
        hit.canon = hit.rev ? rc : fwd;
        due_kmers.push_back(hit);
      end
    end else begin
      mdl_run = 0;
    end
    mdl_index = mdl_index + cke_pkg::START_W'(1);
    if (eor) begin
      mdl_window = '0;
      mdl_run    = 0;
      mdl_index  = '0;
    end
  endfunction

  function automatic logic is_base_char(input logic [7:0] ch);
    logic [7:0] folded;
    folded = ch & cke_pkg::FOLD_MASK;
    return (folded == cke_pkg::CHAR_A) || (folded == cke_pkg::CHAR_C) ||
           (folded == cke_pkg::CHAR_G) || (folded == cke_pkg::CHAR_T);
  endfunction

  // valid base letter in random case
  function automatic logic [7:0] rand_base_char();
    logic [7:0] letter;
    case ($urandom_range(3))
      0: letter = cke_pkg::CHAR_A;
      1: letter = cke_pkg::CHAR_C;
      2: letter = cke_pkg::CHAR_G;
      default: letter = cke_pkg::CHAR_T;
    endcase
    return letter | ($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  function automatic logic [7:0] rand_noise_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255)); while (is_base_char(ch));
    return ch;
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic e);
    read_char_t item;
    item.ch  = c;
    item.eor = e;
    read_chars.push_back(item);
    pushed_chars++;
  endfunction

  // well-formed read with a sprinkle of bad characters
  function automatic void push_read(input int len, input logic last_eor);
    for (int i = 0; i < len; i++)
      push_char(($urandom_range(99) < 4) ? rand_noise_char() : rand_base_char(),
                last_eor && (i == len - 1));
  endfunction

  // read of arbitrary bytes
  function automatic void push_junk_read(input int len);
    for (int i = 0; i < len; i++) push_char(8'($urandom_range(255)), i == len - 1);
  endfunction

  function automatic void set_idle(input int mode);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 62; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 62; end
      default: begin send_idle = 22; recv_stall = 22; end
    endcase
  endfunction

  // hold until every request is taken and every k-mer has come back
  task automatic wait_drain();
    do @(negedge clk); while (read_chars.size() != 0 || s_tvalid || due_kmers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_klen(input logic [cke_pkg::KLEN_W-1:0] v);
    wait_drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // drive requests from the queue; predict on each accepted one
  always @(posedge clk) begin
    read_char_t nxt;
    if (rst) begin
      s_tvalid   <= 1'b0;
      mdl_klen   = cke_pkg::KLEN_RESET;
      mdl_window = '0;
      mdl_run    = 0;
      mdl_index  = '0;
    end else begin
      if (cfg_we) mdl_klen = cfg_wdata;
      if (s_tvalid && s_tready) extract_kmer(s_tdata, s_tuser[0]);
      if (!s_tvalid || s_tready) begin
        if (read_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = read_chars.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.ch;
          s_tuser  <= nxt.eor;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // stall the output at random
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall);
  end

  // compare each accepted k-mer with the oldest one due
  always @(posedge clk) begin
    kmer_hit_t got;
    kmer_hit_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.start = m_tdata[15:0];
      got.fwd   = m_tdata[79:16];
      got.canon = m_tdata[143:80];
      got.rev   = m_tuser[0];
      if (due_kmers.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected k-mer: start %0d fwd %h canon %h rev %b",
                   got.start, got.fwd, got.canon, got.rev);
      end else begin
        want = due_kmers.pop_front();
        if (got.start !== want.start || got.fwd !== want.fwd ||
            got.canon !== want.canon || got.rev !== want.rev) begin
          err_count++;
          if (err_count <= 10)
            $display("k-mer mismatch: start %0d/%0d fwd %h/%h canon %h/%h rev %b/%b (exp/got)",
                     want.start, got.start, want.fwd, got.fwd,
                     want.canon, got.canon, want.rev, got.rev);
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase_klen[NUM_PHASES];
    int phase_base;
    int klen_eff;
    bit paused;
    phase_klen = '{63, 1, 32, 5, 31, 17, 2, 12, 0, 24};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: length zero acts as one; each base once in mixed case, bad bytes
    set_idle(0);
    write_klen(6'd0);
    push_char(8'h41, 1'b0);        // A
    push_char(8'h63, 1'b0);        // c
    push_char(8'h47, 1'b0);        // G
    push_char(8'h74, 1'b0);        // t
    push_char(8'h00, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'h4E, 1'b0);        // N
    push_char(8'hE1, 1'b0);        // folds to 0xC1, not A
    push_char(8'h20, 1'b0);        // folds to zero
    push_char(8'h67, 1'b1);        // g closing a read
    push_char(8'h4E, 1'b1);        // bad character closing a read
    push_char(8'h43, 1'b0);        // C at position zero
    push_char(8'h54, 1'b1);        // T

    // palindrome tie, then a length change in the middle of a read
    write_klen(6'd2);
    push_char(8'h61, 1'b0);        // a
    push_char(8'h54, 1'b0);        // T: AT is its own complement
    push_char(8'h63, 1'b0);        // c
    write_klen(6'd3);
    push_char(8'h47, 1'b1);        // G: TCG from bases already held

    // random phases over several lengths and idling modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idle(p % 4);
      write_klen(cke_pkg::KLEN_W'(phase_klen[p]));
      klen_eff = (phase_klen[p] == 0) ? 1 : ((phase_klen[p] > 32) ? 32 : phase_klen[p]);
      phase_base = pushed_chars;
      paused = 1'b0;
      while (pushed_chars - phase_base < PHASE_CHARS) begin
        // pause the sender once until the output side has caught up
        if (!paused && pushed_chars - phase_base >= PHASE_CHARS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 15) push_junk_read($urandom_range(12, 1));
        else push_read($urandom_range(klen_eff + 12, 1), $urandom_range(99) < 90);
      end
    end

    wait_drain();
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
design/cke_pkg.sv
design/cke_cell.sv
design/canonical_kmer_extractor.sv
tb/tb.sv
